/* rtl/core/height_grid_vertex_normals_top_macros.svh */
// assertion macros for the height grid vertex normals block
// used by the port checker, no other dependencies
`ifndef HEIGHT_GRID_VERTEX_NORMALS_TOP_MACROS_SVH
`define HEIGHT_GRID_VERTEX_NORMALS_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define HGVN_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("hgvn check failed");
// next-cycle implication checked outside reset
`define HGVN_ASSERT_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("hgvn check failed");
`endif

/* rtl/core/hgvn_pkg.sv */
// shared types and constants for the height grid vertex normals block
// no dependencies
package hgvn_pkg;
  localparam int unsigned DefMaxColumns = 64;
  localparam int unsigned DefMaxRows    = 64;
  localparam int unsigned DefHeightBits = 16;
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned CfgDataBits   = 16;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_XSPACE  = 2'd2,
    CFG_YSPACE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV, N_DONE
  } norm_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_WAIT, S_FACET, S_NORM, S_FINAL, S_FNORM, S_OUT
  } seq_state_t;
endpackage

/* rtl/core/hgvn_norm.sv */
// shared vector normalizer: shift to [2^29,2^30), bit-serial root, bit-serial divide
// depends on hgvn_pkg
module hgvn_norm (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [63:0]      vec_in [3],
  output logic                    done,
  output logic signed [31:0]      vec_out [3]
);
  import hgvn_pkg::*;

  norm_state_t state_r, state_nxt;
  logic [63:0] mag_r [3];
  logic        neg_r [3];
  logic [63:0] sq_r;
  logic [63:0] rem_r, res_r, bit_r;
  logic [31:0] len_r;
  logic [1:0]  k_r;
  logic [5:0]  cnt_r;
  logic [61:0] dq_r;
  logic [31:0] drem_r;
  logic signed [31:0] out_r [3];
  logic [63:0] m;
  logic zero;

  always_comb begin
    m = mag_r[0];
    if (mag_r[1] > m) m = mag_r[1];
    if (mag_r[2] > m) m = mag_r[2];
    zero = (m == 64'd0);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      N_IDLE:  if (start) state_nxt = N_SHIFT;
      N_SHIFT: if (zero) state_nxt = N_DONE;
               else if (m < 64'h4000_0000 && m >= 64'h2000_0000) state_nxt = N_SQ;
      N_SQ:    if (k_r == 2'd2) state_nxt = N_SQRT;
      N_SQRT:  if (bit_r == 64'd0) state_nxt = N_DIV;
      N_DIV:   if (k_r == 2'd2 && cnt_r == 6'd0) state_nxt = N_DONE;
      N_DONE:  state_nxt = N_IDLE;
      default: state_nxt = N_IDLE;
    endcase
  end

  assign done = (state_r == N_DONE);
  assign vec_out = out_r;

  logic [32:0] dtrial;
  assign dtrial = {drem_r, dq_r[61]} - {1'b0, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    unique case (state_r)
      N_IDLE: if (start) begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= vec_in[i][63];
          mag_r[i] <= vec_in[i][63] ? 64'd0 - 64'(vec_in[i]) : 64'(vec_in[i]);
          out_r[i] <= '0;
        end
        sq_r <= '0;
        k_r  <= '0;
      end
      N_SHIFT: if (!zero) begin
        if (m >= 64'h4000_0000) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else if (m < 64'h2000_0000) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
        end
      end
      N_SQ: begin
        sq_r <= sq_r + mag_r[k_r][31:0] * mag_r[k_r][31:0];
        k_r  <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        if (k_r == 2'd2) begin
          rem_r <= sq_r + mag_r[k_r][31:0] * mag_r[k_r][31:0];
          res_r <= '0;
          bit_r <= 64'h4000_0000_0000_0000;
        end
      end
      N_SQRT: begin
        if (bit_r != 64'd0) begin
          if (rem_r >= res_r + bit_r) begin
            rem_r <= rem_r - (res_r + bit_r);
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          len_r  <= (res_r[31:0] == 32'd0) ? 32'd1 : res_r[31:0];
          dq_r   <= {mag_r[0][31:0], 30'd0};
          drem_r <= '0;
          cnt_r  <= 6'd61;
        end
      end
      N_DIV: begin
        if (cnt_r == 6'd0) begin
          // last quotient bit comes straight from the trial subtract
          out_r[k_r] <= neg_r[k_r]
            ? 32'd0 - {dq_r[30:0], ~dtrial[32]} : {dq_r[30:0], ~dtrial[32]};
          if (k_r != 2'd2) begin
            k_r    <= k_r + 2'd1;
            dq_r   <= {mag_r[k_r + 2'd1][31:0], 30'd0};
            drem_r <= '0;
            cnt_r  <= 6'd61;
          end
        end else begin
          if (!dtrial[32]) begin
            drem_r <= dtrial[31:0];
            dq_r   <= {dq_r[60:0], 1'b1};
          end else begin
            drem_r <= {drem_r[30:0], dq_r[61]};
            dq_r   <= {dq_r[60:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

/* rtl/core/height_grid_vertex_normals_top.sv */
// top level of the height grid vertex normals block: store, sequencer, outputs
// depends on hgvn_pkg and hgvn_norm
//
// usage: drive in_operation/in_column/in_row/in_height with start high while
// busy is low; the word is taken at that edge. exactly one result word comes
// back per input word, shown for one cycle with done high; the receiver
// cannot stall it. clear, write and unused codes go straight from idle to
// the output state. a query reads nine heights from the store (one per
// cycle), then runs five normalizations (shift, squares, bit-serial root,
// bit-serial divide) on one shared unit; the divider takes most of the time.
// config writes (cfg_we, cfg_index, cfg_data) land at once; the user must
// make them only while idle, as the block itself does not enforce it.
// reset (rst_n low, synchronous) clears min/max and the registers to their
// defaults; the height store is not cleared and must be written before use.
module height_grid_vertex_normals_top #(
  parameter int unsigned MAX_COLUMNS = hgvn_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = hgvn_pkg::DefMaxRows,
  parameter int unsigned HEIGHT_BITS = hgvn_pkg::DefHeightBits
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_operation,
  input  logic [5:0]                          in_column,
  input  logic [5:0]                          in_row,
  input  logic signed [HEIGHT_BITS-1:0]       in_height,
  output logic                                done,
  output logic signed [15:0]                  out_normal_x,
  output logic signed [15:0]                  out_normal_y,
  output logic signed [15:0]                  out_normal_z,
  output logic signed [HEIGHT_BITS-1:0]       out_height_min,
  output logic signed [HEIGHT_BITS-1:0]       out_height_max,
  output logic                                out_out_of_range,
  input  logic                                cfg_we,
  input  logic [hgvn_pkg::CfgIdxBits-1:0]     cfg_index,
  input  logic [hgvn_pkg::CfgDataBits-1:0]    cfg_data
);
  import hgvn_pkg::*;

  localparam int unsigned CB = $clog2(MAX_COLUMNS);
  localparam int unsigned RB = $clog2(MAX_ROWS);
  localparam int unsigned AB = CB + RB;
  localparam logic signed [HEIGHT_BITS-1:0] HMax = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
  localparam logic signed [HEIGHT_BITS-1:0] HMin = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

  // config registers
  logic [6:0]  cols_r, rows_r;
  logic [15:0] xsp_r, ysp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 7'd64;
      rows_r <= 7'd64;
      xsp_r  <= 16'd256;
      ysp_r  <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COLUMNS: cols_r <= cfg_data[6:0];
        CFG_ROWS:    rows_r <= cfg_data[6:0];
        CFG_XSPACE:  xsp_r  <= cfg_data;
        CFG_YSPACE:  ysp_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes saturated to [3, max]
  logic [10:0] ec, er;
  always_comb begin
    ec = (cols_r < 7'd3) ? 11'd3
       : ((11'(cols_r) > 11'(MAX_COLUMNS)) ? 11'(MAX_COLUMNS) : 11'(cols_r));
    er = (rows_r < 7'd3) ? 11'd3
       : ((11'(rows_r) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(rows_r));
  end
  logic [16:0] dx, dy;
  assign dx = (xsp_r == 16'd0) ? 17'd1 : {1'b0, xsp_r};
  assign dy = (ysp_r == 16'd0) ? 17'd1 : {1'b0, ysp_r};

  // height store, one write port and one read port, registered read
  logic signed [HEIGHT_BITS-1:0] mem [MAX_COLUMNS*MAX_ROWS];
  logic        mem_we;
  logic [AB-1:0] mem_waddr, mem_raddr;
  logic signed [HEIGHT_BITS-1:0] mem_rd_r;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= in_height;
    mem_rd_r <= mem[mem_raddr];
  end

  seq_state_t state_r, state_nxt;
  logic signed [HEIGHT_BITS-1:0] min_r, max_r;
  logic [1:0] op_r;
  logic oor_r;
  logic [10:0] c_r, r_r;
  logic [3:0] rd_cnt_r;
  logic signed [HEIGHT_BITS-1:0] h_r [9];
  logic [1:0] facet_r;
  logic signed [63:0] acc_r [3];
  logic signed [63:0] nvec [3];
  logic signed [31:0] nres [3];
  logic norm_start, norm_done;
  logic signed [15:0] nx_r, ny_r, nz_r;

  hgvn_norm u_norm (
    .clk(clk), .rst_n(rst_n), .start(norm_start), .vec_in(nvec),
    .done(norm_done), .vec_out(nres)
  );

  logic oor_in;
  assign oor_in = (11'(in_column) >= ec) || (11'(in_row) >= er);

  // clamped point
  logic [10:0] cc, rc;
  always_comb begin
    cc = 11'(in_column);
    if (cc < 11'd1) cc = 11'd1;
    if (cc > ec - 11'd2) cc = ec - 11'd2;
    rc = 11'(in_row);
    if (rc < 11'd1) rc = 11'd1;
    if (rc > er - 11'd2) rc = er - 11'd2;
  end

  // read order: 3x3 patch around (c,r), offset (rd/3 - 1, rd%3 - 1)
  // store address is column * MAX_ROWS + row, kept at full address width
  logic [1:0] ox, oy;
  always_comb begin
    ox = (rd_cnt_r < 4'd3) ? 2'd0 : ((rd_cnt_r < 4'd6) ? 2'd1 : 2'd2);
    oy = 2'(rd_cnt_r - 4'(ox) * 4'd3);
    mem_raddr = AB'(c_r + 11'(ox) - 11'd1) * AB'(MAX_ROWS)
              + AB'(r_r + 11'(oy) - 11'd1);
    mem_we    = (state_r == S_IDLE) && start && (op_t'(in_operation) == OP_WRITE) && !oor_in;
    mem_waddr = AB'(in_column) * AB'(MAX_ROWS) + AB'(in_row);
  end

  // facet vector from the patch: cell offsets (fi,fj) in {0,1}
  logic [1:0] fi, fj;
  logic [3:0] hi0, hix, hiy;
  logic signed [HEIGHT_BITS+1:0] h0, dhx, dhy;
  always_comb begin
    fi = {1'b0, facet_r[0]};
    fj = {1'b0, facet_r[1]};
    hi0 = 4'(fi) * 4'd3 + 4'(fj);
    hix = hi0 + 4'd3;
    hiy = hi0 + 4'd1;
    h0  = (HEIGHT_BITS+2)'(h_r[hi0]);
    dhx = (HEIGHT_BITS+2)'(h_r[hix]) - h0;
    dhy = (HEIGHT_BITS+2)'(h_r[hiy]) - h0;
    if (state_r == S_FACET) begin
      nvec[0] = -(64'(signed'(dy)) * 64'(dhx)) <<< 8;
      nvec[1] = -(64'(signed'(dx)) * 64'(dhy)) <<< 8;
      nvec[2] = 64'(signed'(dx)) * 64'(signed'(dy));
    end else begin
      nvec = acc_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = (op_t'(in_operation) == OP_QUERY) ? S_READ : S_OUT;
      S_READ:  if (rd_cnt_r == 4'd8) state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_FACET;
      S_FACET: state_nxt = S_NORM;
      S_NORM:  if (norm_done) state_nxt = (facet_r == 2'd3) ? S_FINAL : S_FACET;
      S_FINAL: state_nxt = S_FNORM;
      S_FNORM: if (norm_done) state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    norm_start = (state_r == S_FACET) || (state_r == S_FINAL);
    busy = (state_r != S_IDLE);
    done = (state_r == S_OUT);
  end

  function automatic logic signed [15:0] trunc14(input logic signed [31:0] v);
    logic [31:0] mg;
    logic [15:0] t;
    mg = v[31] ? 32'd0 - 32'(v) : 32'(v);
    t = mg[31:16];
    return v[31] ? 16'd0 - t : t;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      min_r   <= HMax;
      max_r   <= HMin;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && start) begin
        if (op_t'(in_operation) == OP_CLEAR) begin
          min_r <= HMax;
          max_r <= HMin;
        end else if (mem_we) begin
          if (in_height < min_r) min_r <= in_height;
          if (in_height > max_r) max_r <= in_height;
        end
      end
    end
    if (state_r == S_IDLE && start) begin
      op_r  <= in_operation;
      oor_r <= oor_in;
      c_r   <= cc;
      r_r   <= rc;
      rd_cnt_r <= '0;
      facet_r  <= '0;
      nx_r <= '0; ny_r <= '0; nz_r <= '0;
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end
    if (state_r == S_READ) rd_cnt_r <= rd_cnt_r + 4'd1;
    // read data lands in the cycle after its address
    if ((state_r == S_READ && rd_cnt_r != 4'd0) || state_r == S_WAIT)
      h_r[rd_cnt_r - 4'd1] <= mem_rd_r;
    if (state_r == S_NORM && norm_done) begin
      for (int i = 0; i < 3; i++) acc_r[i] <= acc_r[i] + 64'(nres[i]);
      facet_r <= facet_r + 2'd1;
    end
    if (state_r == S_FNORM && norm_done) begin
      nx_r <= trunc14(nres[0]);
      ny_r <= trunc14(nres[1]);
      nz_r <= trunc14(nres[2]);
    end
  end

  always_comb begin
    out_normal_x     = nx_r;
    out_normal_y     = ny_r;
    out_normal_z     = nz_r;
    out_height_min   = min_r;
    out_height_max   = max_r;
    out_out_of_range = (op_t'(op_r) == OP_WRITE || op_t'(op_r) == OP_QUERY) ? oor_r : 1'b0;
  end
endmodule

/* rtl/core/hgvn_checker.sv */
// port-level checker for the height grid vertex normals block, with its bind
// depends on height_grid_vertex_normals_top_macros.svh
`include "height_grid_vertex_normals_top_macros.svh"
module hgvn_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic done,
  input logic signed [15:0] out_normal_x,
  input logic signed [15:0] out_height_min,
  input logic signed [15:0] out_height_max
);
  // a taken word makes the block busy next cycle
  `HGVN_ASSERT_NXT(a_take_busy, start && !busy, busy)
  // a result ends the job
  `HGVN_ASSERT_NXT(a_done_idle, done, !busy && !done)
  // done only while working
  `HGVN_ASSERT_IMP(a_done_busy, done, busy)
  // x component of the normal stays within unit range
  `HGVN_ASSERT_IMP(a_norm_range, done, out_normal_x <= 16'sd16384 && out_normal_x >= -16'sd16384)
  // while min is below the top value, min stays at or below max
  `HGVN_ASSERT_IMP(a_minmax, done && out_height_min != 16'sh7fff, out_height_min <= out_height_max)
endmodule

bind height_grid_vertex_normals_top hgvn_checker u_hgvn_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
  .out_normal_x(out_normal_x), .out_height_min(out_height_min),
  .out_height_max(out_height_max)
);
